### sv/stbk_pkg.sv
// Shared types and constants for the soft timer bank.
package stbk_pkg;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;

    localparam logic [30:0] RUN_WRAP = 31'h7FFF_FFFF;

    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_START_ONCE = 3'd1;
    localparam logic [2:0] ACT_START_AUTO = 3'd2;
    localparam logic [2:0] ACT_STOP       = 3'd3;
    localparam logic [2:0] ACT_CHECK      = 3'd4;
    localparam logic [2:0] ACT_ELAPSED    = 3'd5;
    localparam logic [2:0] ACT_DELAY      = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_CHECK
    } cell_op_t;

    // Command token that walks the cell chain.
    typedef struct packed {
        logic        valid;
        cell_op_t    op;
        logic        auto_mode;
        logic [7:0]  id;
        logic [31:0] period;
        logic        hit;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } stbk_state_t;

endpackage

### sv/soft_timer_bank.sv
// Top level of the soft timer bank: request decode, global counters, cell chain.
//
//   channel  dir  payload
//   s_*      in   tuser: action; tdata: timer_id, period, last_time
//   m_*      out  tdata: expired, id_error, run_time, elapsed_ticks, delay_done,
//                 tenth_pulse
//
// The bank holds one request at a time: after acceptance its command token is
// registered and steps through the chain of NUM_TIMERS cells, one per cycle.
// The result waits in an output register; a new request is taken meanwhile.
// If the output register is still full when the token leaves the chain, the
// bank holds until it drains. Reset clears every timer and counter at once.
module soft_timer_bank
    import stbk_pkg::*;
#(
    parameter int NUM_TIMERS   = 8,
    parameter int PULSE_DIVIDE = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [70:40] last_time, [39:8] period, [7:0] timer_id
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] action
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [65] tenth_pulse, [64] delay_done, [63:33] elapsed_ticks, [32:2] run_time,
    // [1] id_error, [0] expired
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [8:0] NUM_TIMERS_L = 9'(NUM_TIMERS);
    localparam logic [3:0] DIVIDE_L     = 4'(PULSE_DIVIDE);

    logic [2:0]  action;
    logic [7:0]  timer_id;
    logic [31:0] period;
    logic [30:0] last_time;

    assign action    = s_tuser[2:0];
    assign timer_id  = s_tdata[7:0];
    assign period    = s_tdata[39:8];
    assign last_time = s_tdata[70:40];

    stbk_state_t state_reg, state_next;
    logic        accept;
    logic        out_free;
    logic        load_out;

    logic [31:0] delay_count_reg, delay_count_next;
    logic        delay_flag_reg, delay_flag_next;
    logic [30:0] run_reg, run_next;
    logic [3:0]  div_reg, div_next;
    logic [30:0] elapsed_reg, elapsed_next;
    logic        pulse_reg, pulse_next;
    logic        id_err_reg, id_err_next;
    logic        hit_reg;
    tok_t        launch_reg, launch_next;

    logic        needs_id;
    logic        id_err;
    logic [31:0] delay_dec;
    logic [30:0] run_inc;
    logic [3:0]  div_inc;
    logic [31:0] diff;
    logic [30:0] wrap_diff;
    logic        hit_src;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    tok_t tok [0:NUM_TIMERS];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Request decode and global counters
    always_comb begin
        needs_id  = (action == ACT_START_ONCE) || (action == ACT_START_AUTO) ||
                    (action == ACT_STOP) || (action == ACT_CHECK);
        id_err    = needs_id && ({1'b0, timer_id} >= NUM_TIMERS_L);
        delay_dec = delay_count_reg - 32'd1;
        run_inc   = run_reg + 31'd1;
        div_inc   = div_reg + 4'd1;
        diff      = {1'b0, run_reg} - {1'b0, last_time};
        wrap_diff = run_reg + ~last_time;

        delay_count_next = delay_count_reg;
        delay_flag_next  = delay_flag_reg;
        run_next         = run_reg;
        div_next         = div_reg;
        elapsed_next     = elapsed_reg;
        pulse_next       = pulse_reg;
        id_err_next      = id_err_reg;

        launch_next           = launch_reg;
        launch_next.valid     = 1'b0;
        launch_next.op        = OP_NOP;
        launch_next.auto_mode = (action == ACT_START_AUTO);
        launch_next.id        = timer_id;
        launch_next.period    = period;
        launch_next.hit       = 1'b0;

        if (accept) begin
            launch_next.valid = 1'b1;
            elapsed_next      = '0;
            pulse_next        = 1'b0;
            id_err_next       = id_err;
            if (!id_err) begin
                case (action) inside
                    ACT_TICK: begin
                        launch_next.op = OP_TICK;
                        if (delay_count_reg != 32'd0) begin
                            delay_count_next = delay_dec;
                            if (delay_dec == 32'd0) begin
                                delay_flag_next = 1'b1;
                            end
                        end
                        run_next = (run_inc == RUN_WRAP) ? 31'd0 : run_inc;
                        if (div_inc >= DIVIDE_L) begin
                            div_next   = 4'd0;
                            pulse_next = 1'b1;
                        end else begin
                            div_next = div_inc;
                        end
                    end
                    ACT_START_ONCE, ACT_START_AUTO: launch_next.op = OP_START;
                    ACT_STOP:  launch_next.op = OP_STOP;
                    ACT_CHECK: launch_next.op = OP_CHECK;
                    ACT_ELAPSED: begin
                        elapsed_next = diff[31] ? wrap_diff : diff[30:0];
                    end
                    ACT_DELAY: begin
                        if (period != 32'd0) begin
                            delay_count_next = (period == 32'd1) ? 32'd2 : period;
                            delay_flag_next  = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tok[NUM_TIMERS].valid) begin
                    state_next = out_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        hit_src  = hit_reg;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_WALK: begin
                load_out = tok[NUM_TIMERS].valid && out_free;
                hit_src  = tok[NUM_TIMERS].hit;
            end
            ST_FINISH: load_out = out_free;
            default: ;
        endcase
    end

    assign tok[0] = launch_reg;

    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
        stbk_cell #(
            .CELL_IDX(i)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            delay_count_reg  <= '0;
            delay_flag_reg   <= 1'b0;
            run_reg          <= '0;
            div_reg          <= '0;
            launch_reg.valid <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            delay_count_reg <= delay_count_next;
            delay_flag_reg  <= delay_flag_next;
            run_reg         <= run_next;
            div_reg         <= div_next;
            launch_reg      <= launch_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        pulse_reg   <= pulse_next;
        id_err_reg  <= id_err_next;
        if (state_reg == ST_WALK && tok[NUM_TIMERS].valid) begin
            hit_reg <= tok[NUM_TIMERS].hit;
        end
        if (load_out) begin
            m_tdata_reg <= {6'd0, pulse_reg, delay_flag_reg, elapsed_reg, run_reg,
                            id_err_reg, hit_src};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sv/stbk_cell.sv
// One timer slot of the chain: count, reload, expired flag and mode.
module stbk_cell
    import stbk_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic [31:0] count_reg, count_next;
    logic [31:0] reload_reg, reload_next;
    logic        flag_reg, flag_next;
    logic        auto_reg, auto_next;
    tok_t        tok_reg, tok_next;
    logic        match;
    logic [31:0] dec;

    assign match = (tok_in.id == 8'(CELL_IDX));
    assign dec   = count_reg - 32'd1;

    always_comb begin
        count_next  = count_reg;
        reload_next = reload_reg;
        flag_next   = flag_reg;
        auto_next   = auto_reg;
        tok_next    = tok_in;
        if (tok_in.valid) begin
            case (tok_in.op)
                OP_TICK: begin
                    if (count_reg != 32'd0) begin
                        count_next = dec;
                        if (dec == 32'd0) begin
                            flag_next = 1'b1;
                            if (auto_reg) begin
                                count_next = reload_reg;
                            end
                        end
                    end
                end
                OP_START: begin
                    if (match) begin
                        count_next  = tok_in.period;
                        reload_next = tok_in.period;
                        flag_next   = 1'b0;
                        auto_next   = tok_in.auto_mode;
                    end
                end
                OP_STOP: begin
                    if (match) begin
                        count_next = 32'd0;
                        flag_next  = 1'b0;
                        auto_next  = 1'b0;
                    end
                end
                OP_CHECK: begin
                    if (match) begin
                        tok_next.hit = tok_in.hit | flag_reg;
                        flag_next    = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            reload_reg    <= '0;
            flag_reg      <= 1'b0;
            auto_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            flag_reg   <= flag_next;
            auto_reg   <= auto_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### sv/stbk_checker.sv
// Port-level checks for the soft timer bank, bound to the top level.
module stbk_checker
    import stbk_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request in flight: no back-to-back acceptance.
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A rejected id never reports an expiry.
    a_err_no_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[0])
        else $error("expired set with id error");

    // A tick pulse never comes with an expiry or an elapsed value.
    a_pulse_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] |-> !m_tdata[0] && !m_tdata[1] && m_tdata[63:33] == 31'd0)
        else $error("pulse mixed with other result");

endmodule

bind soft_timer_bank stbk_checker u_stbk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

### bench/tb_soft_timer_bank.sv
// Self-checking bench for soft_timer_bank: directed table, then random requests.
`timescale 1ns / 1ps

module tb_soft_timer_bank;
    import stbk_pkg::*;

    localparam int          NUM_TIMERS   = 8;
    localparam int          PULSE_DIVIDE = 10;
    localparam int          ID_W         = $clog2(NUM_TIMERS);
    localparam logic [2:0]  ACT_UNUSED   = 3'd7;
    localparam int          RANDOM_REQS  = 1200;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 2 * (NUM_TIMERS + 2);
    localparam int          LONG_HOLD    = 300;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  timer_id;
        logic [31:0] period;
        logic [30:0] last_time;
    } bank_req_t;

    // same bit order as m_tdata[65:0]
    typedef struct packed {
        logic        tenth_pulse;
        logic        delay_done;
        logic [30:0] elapsed_ticks;
        logic [30:0] run_time;
        logic        id_error;
        logic        expired;
    } bank_result_t;

    typedef struct {
        bank_req_t    req;
        bit           fixed;
        bank_result_t want;
    } script_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    soft_timer_bank #(
        .NUM_TIMERS  (NUM_TIMERS),
        .PULSE_DIVIDE(PULSE_DIVIDE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [31:0] timer_count  [NUM_TIMERS];
    logic [31:0] timer_reload [NUM_TIMERS];
    logic        timer_flag   [NUM_TIMERS];
    logic        timer_auto   [NUM_TIMERS];
    logic [31:0] delay_left;
    logic        delay_flag;
    logic [30:0] run_ticks;
    logic [3:0]  pulse_div;

    bank_result_t pending_results[$];
    script_row_t  script[$];
    int           fault_count = 0;
    int           sent_count  = 0;
    int           seen_count  = 0;
    int           cycle_count = 0;

    task automatic bank_step(input bank_req_t rq, output bank_result_t res);
        int            k;
        logic [31:0]   nxt;
        logic [31:0]   per;
        logic [ID_W-1:0] idx;
        bit            needs_id;
        needs_id = rq.action inside {ACT_START_ONCE, ACT_START_AUTO, ACT_STOP, ACT_CHECK};
        idx = rq.timer_id[ID_W-1:0];
        res = '0;
        if (needs_id && rq.timer_id >= NUM_TIMERS) begin
            res.id_error = 1'b1;
        end else begin
            case (rq.action)
                ACT_TICK: begin
                    if (delay_left != 0) begin
                        delay_left = delay_left - 1;
                        if (delay_left == 0)
                            delay_flag = 1'b1;
                    end
                    for (k = 0; k < NUM_TIMERS; k++) begin
                        if (timer_count[k] != 0) begin
                            timer_count[k] = timer_count[k] - 1;
                            if (timer_count[k] == 0) begin
                                timer_flag[k] = 1'b1;
                                if (timer_auto[k])
                                    timer_count[k] = timer_reload[k];
                            end
                        end
                    end
                    nxt = ({1'b0, run_ticks} + 32'd1) & {1'b0, RUN_WRAP};
                    run_ticks = (nxt == {1'b0, RUN_WRAP}) ? 31'd0 : nxt[30:0];
                    pulse_div = pulse_div + 4'd1;
                    if (pulse_div >= PULSE_DIVIDE) begin
                        pulse_div = 4'd0;
                        res.tenth_pulse = 1'b1;
                    end
                end
                ACT_START_ONCE, ACT_START_AUTO: begin
                    timer_count[idx]  = rq.period;
                    timer_reload[idx] = rq.period;
                    timer_flag[idx]   = 1'b0;
                    timer_auto[idx]   = (rq.action == ACT_START_AUTO);
                end
                ACT_STOP: begin
                    timer_count[idx] = '0;
                    timer_flag[idx]  = 1'b0;
                    timer_auto[idx]  = 1'b0;
                end
                ACT_CHECK: begin
                    res.expired = timer_flag[idx];
                    timer_flag[idx] = 1'b0;
                end
                ACT_ELAPSED: begin
                    if (run_ticks >= rq.last_time)
                        res.elapsed_ticks = run_ticks - rq.last_time;
                    else
                        res.elapsed_ticks = RUN_WRAP - rq.last_time + run_ticks;
                end
                ACT_DELAY: begin
                    per = rq.period;
                    if (per != 0) begin
                        if (per == 1)
                            per = 2;
                        delay_left = per;
                        delay_flag = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        res.run_time   = run_ticks;
        res.delay_done = delay_flag;
    endtask

    function automatic bank_result_t res_of(logic e, logic err, logic [30:0] rt,
                                            logic [30:0] el, logic dd, logic tp);
        bank_result_t r;
        r.expired       = e;
        r.id_error      = err;
        r.run_time      = rt;
        r.elapsed_ticks = el;
        r.delay_done    = dd;
        r.tenth_pulse   = tp;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] act, input logic [7:0] id,
                           input logic [31:0] per, input logic [30:0] last,
                           input bit fixed, input bank_result_t want);
        script_row_t row;
        row.req   = '{act, id, per, last};
        row.fixed = fixed;
        row.want  = want;
        script.push_back(row);
    endtask

    // one request: offer, wait for acceptance, record expectation, optional gap
    task automatic issue(input bank_req_t rq, input bit fixed, input bank_result_t want);
        bank_result_t predicted;
        int           gap;
        s_tvalid <= 1'b1;
        s_tuser  <= rq.action;
        s_tdata  <= {1'b0, rq.last_time, rq.period, rq.timer_id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bank_step(rq, predicted);
        pending_results.push_back(fixed ? want : predicted);
        sent_count++;
        gap = ((sent_count / 120) % 4 == 2) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 8'($urandom_range(0, NUM_TIMERS - 1));
        else if (r < 93)
            return 8'($urandom_range(NUM_TIMERS, 255));
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 12);
        else if (r < 90)
            return $urandom_range(13, 60);
        return $urandom;
    endfunction

    task automatic random_request(output bank_req_t rq);
        int unsigned r;
        int unsigned s;
        r = $urandom_range(0, 99);
        rq.timer_id  = 8'($urandom);
        rq.period    = $urandom;
        rq.last_time = 31'($urandom);
        if (r < 40) begin
            rq.action = ACT_TICK;
        end else if (r < 52) begin
            rq.action   = $urandom_range(0, 1) ? ACT_START_AUTO : ACT_START_ONCE;
            rq.timer_id = pick_id();
            rq.period   = pick_period();
        end else if (r < 58) begin
            rq.action   = ACT_STOP;
            rq.timer_id = pick_id();
        end else if (r < 74) begin
            rq.action   = ACT_CHECK;
            rq.timer_id = pick_id();
        end else if (r < 82) begin
            rq.action = ACT_ELAPSED;
            s = $urandom_range(0, 3);
            if (s < 2)
                rq.last_time = 31'($urandom_range(0, run_ticks));
            else if (s == 2)
                rq.last_time = 31'(RUN_WRAP - $urandom_range(0, 2));
        end else if (r < 92) begin
            rq.action = ACT_DELAY;
            s = $urandom_range(0, 9);
            if (s < 3)
                rq.period = s;
            else if (s < 9)
                rq.period = $urandom_range(3, 30);
        end else begin
            rq.action = ACT_UNUSED;
        end
    endtask

    // result side
    initial begin
        bank_result_t got;
        bank_result_t want;
        int           stall;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (seen_count == 250)
                stall = LONG_HOLD;
            else if ((seen_count / 90) % 4 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            got = m_tdata[65:0];
            seen_count++;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result %0d: none expected, got %h", seen_count, got);
            end else begin
                want = pending_results.pop_front();
                if (got.expired !== want.expired || got.id_error !== want.id_error ||
                    got.run_time !== want.run_time ||
                    got.elapsed_ticks !== want.elapsed_ticks ||
                    got.delay_done !== want.delay_done ||
                    got.tenth_pulse !== want.tenth_pulse) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"result %0d: want exp=%0d err=%0d run=%0d el=%0d dd=%0d ",
                                  "tp=%0d | got exp=%0d err=%0d run=%0d el=%0d dd=%0d tp=%0d"},
                                 seen_count, want.expired, want.id_error, want.run_time,
                                 want.elapsed_ticks, want.delay_done, want.tenth_pulse,
                                 got.expired, got.id_error, got.run_time,
                                 got.elapsed_ticks, got.delay_done, got.tenth_pulse);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("soft_timer_bank: mismatch");
        $finish;
    end

    initial begin
        bank_req_t rq;
        int        useful;
        int        k;

        for (k = 0; k < NUM_TIMERS; k++) begin
            timer_count[k]  = '0;
            timer_reload[k] = '0;
            timer_flag[k]   = 1'b0;
            timer_auto[k]   = 1'b0;
        end
        delay_left = '0;
        delay_flag = 1'b0;
        run_ticks  = '0;
        pulse_div  = '0;

        add_row(ACT_ELAPSED,    8'd0,  32'd0,        31'd0, 1'b1,
                res_of(1'b0, 1'b0, 31'd0, 31'd0, 1'b0, 1'b0));
        add_row(ACT_TICK,       8'd0,  32'd0,        31'd0, 1'b1,
                res_of(1'b0, 1'b0, 31'd1, 31'd0, 1'b0, 1'b0));
        add_row(ACT_START_ONCE, 8'd0,  32'd3,        31'd0, 1'b0, '0);
        add_row(ACT_START_AUTO, 8'd7,  32'd2,        31'd0, 1'b0, '0);
        add_row(ACT_START_ONCE, 8'd8,  32'hFFFFFFFF, 31'd0, 1'b1,
                res_of(1'b0, 1'b1, 31'd1, 31'd0, 1'b0, 1'b0));
        add_row(ACT_STOP,       8'hFF, 32'd0,        31'd0, 1'b1,
                res_of(1'b0, 1'b1, 31'd1, 31'd0, 1'b0, 1'b0));
        add_row(ACT_CHECK,      8'hFF, 32'd0,     RUN_WRAP, 1'b1,
                res_of(1'b0, 1'b1, 31'd1, 31'd0, 1'b0, 1'b0));
        add_row(ACT_DELAY,      8'd0,  32'd0,        31'd0, 1'b1,
                res_of(1'b0, 1'b0, 31'd1, 31'd0, 1'b0, 1'b0));
        add_row(ACT_DELAY,      8'd0,  32'd1,        31'd0, 1'b0, '0);
        add_row(ACT_START_ONCE, 8'd1,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_START_AUTO, 8'd2,  32'hFFFFFFFF, 31'd0, 1'b0, '0);
        add_row(ACT_TICK,       8'd0,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_TICK,       8'd0,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_CHECK,      8'd7,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_CHECK,      8'd7,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_TICK,       8'd0,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_CHECK,      8'd0,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_STOP,       8'd2,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_ELAPSED,    8'd0,  32'd0,     RUN_WRAP, 1'b0, '0);
        add_row(ACT_ELAPSED,    8'd0,  32'd0, RUN_WRAP - 31'd1, 1'b0, '0);
        add_row(ACT_UNUSED,     8'hFF, 32'hFFFFFFFF, RUN_WRAP, 1'b0, '0);
        add_row(ACT_START_AUTO, 8'd3,  32'd1,        31'd0, 1'b0, '0);
        add_row(ACT_CHECK,      8'd1,  32'd0,        31'd0, 1'b0, '0);
        add_row(ACT_DELAY,      8'd0,  32'hFFFFFFFF, 31'd0, 1'b0, '0);
        add_row(ACT_START_ONCE, 8'd7,  32'hFFFFFFFF, 31'd0, 1'b0, '0);

        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i])
            issue(script[i].req, script[i].fixed, script[i].want);

        useful = 0;
        while (useful < RANDOM_REQS) begin
            if (useful == 700) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge aclk);
            end
            random_request(rq);
            if (rq.action != ACT_UNUSED &&
                !(rq.action inside {ACT_START_ONCE, ACT_START_AUTO, ACT_STOP, ACT_CHECK} &&
                  rq.timer_id >= NUM_TIMERS))
                useful++;
            issue(rq, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0 && pending_results.size() == 0)
            $display("soft_timer_bank: match");
        else
            $display("soft_timer_bank: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/stbk_pkg.sv
sv/stbk_cell.sv
sv/soft_timer_bank.sv
sv/stbk_checker.sv
bench/tb_soft_timer_bank.sv
